FILE: hw/rtl/bal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bal_pkg
// Types and codes shared by the bounded array list modules.
// ----------------------------------------------------------------------------
package bal_pkg;

	localparam int OP_W   = 2;
	localparam int VAL_W  = 32;
	localparam int POS_W  = 5;
	localparam int STAT_W = 3;
	localparam int CNT_W  = 5;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_DUMP   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_BOUNDS   = 3'd2,
		STAT_NOTFOUND = 3'd3,
		STAT_EMPTY    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_SHIFT,
		S_INS_PUT,
		S_DEL_SRCH,
		S_DEL_SHIFT,
		S_DUMP_RD,
		S_RESP
	} state_t;

	typedef struct packed {
		status_t                  status;
		logic signed [VAL_W-1:0]  entry_value;
		logic        [CNT_W-1:0]  entry_count;
		logic                     last;
	} res_t;

endpackage
`default_nettype wire

FILE: hw/rtl/bal_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bal_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/bal_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bal_seq
// Request sequencer: walks the entry RAM for insert, delete and dump.
// ----------------------------------------------------------------------------
module bal_seq
	import bal_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire op_t                           req_op,
	input  wire logic signed [VAL_W-1:0]       req_value,
	input  wire logic        [POS_W-1:0]       req_pos,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output res_t                               res,
	output logic                               ram_we,
	output logic [$clog2(CAPACITY)-1:0]        ram_waddr,
	output logic [VAL_W-1:0]                   ram_wdata,
	output logic                               ram_re,
	output logic [$clog2(CAPACITY)-1:0]        ram_raddr,
	input  wire logic [VAL_W-1:0]              ram_rdata
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	state_t                 state_q, state_d;
	logic [CW-1:0]          count_q;
	logic [AW-1:0]          idx_q;
	logic [AW-1:0]          pos_q;
	logic [VAL_W-1:0]       val_q;
	status_t                status_q;
	logic [VAL_W-1:0]       value_q;
	logic                   last_q;

	logic                   accept;
	logic                   cnt_full, cnt_zero, pos_bad, pos_end;
	logic [XW-1:0]          idx_x, count_x;
	logic                   ins_done, hit, tail_hit, del_done, at_bottom, is_last;
	status_t                acc_status;

	assign accept   = req_valid && req_ready;
	assign idx_x    = XW'(idx_q);
	assign count_x  = XW'(count_q);
	assign cnt_full = (count_q >= CW'(CAPACITY));
	assign cnt_zero = (count_q == '0);
	assign pos_bad  = (XW'(req_pos) > count_x);
	assign pos_end  = (XW'(req_pos) == count_x);
	assign ins_done = (idx_q == pos_q + AW'(1));
	assign hit      = (ram_rdata == val_q);
	assign tail_hit = (idx_x + XW'(1) == count_x);
	assign del_done = (idx_x + XW'(2) == count_x);
	assign at_bottom = (idx_q == '0);
	assign is_last  = (idx_x + XW'(1) == count_x);

	always_comb begin
		unique case (req_op)
			OP_APPEND: acc_status = cnt_full ? STAT_FULL : STAT_OK;
			OP_INSERT: acc_status = pos_bad ? STAT_BOUNDS : (cnt_full ? STAT_FULL : STAT_OK);
			OP_DELETE: acc_status = STAT_NOTFOUND;
			OP_DUMP:   acc_status = cnt_zero ? STAT_EMPTY : STAT_OK;
			default:   acc_status = STAT_OK;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req_op)
						OP_INSERT: begin
							if (!pos_bad && !cnt_full && !pos_end) begin
								state_d = S_INS_SHIFT;
							end else begin
								state_d = S_RESP;
							end
						end
						OP_DELETE: state_d = cnt_zero ? S_RESP : S_DEL_SRCH;
						OP_DUMP:   state_d = cnt_zero ? S_RESP : S_DUMP_RD;
						default:   state_d = S_RESP;
					endcase
				end
			end
			S_INS_SHIFT: begin
				if (ins_done) begin
					state_d = S_INS_PUT;
				end
			end
			S_INS_PUT: state_d = S_RESP;
			S_DEL_SRCH: begin
				if (hit) begin
					state_d = tail_hit ? S_RESP : S_DEL_SHIFT;
				end else if (at_bottom) begin
					state_d = S_RESP;
				end
			end
			S_DEL_SHIFT: begin
				if (del_done) begin
					state_d = S_RESP;
				end
			end
			S_DUMP_RD: state_d = S_RESP;
			S_RESP: begin
				if (res_ready) begin
					state_d = last_q ? S_IDLE : S_DUMP_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: handshakes and RAM accesses
	always_comb begin
		req_ready = (state_q == S_IDLE);
		res_valid = (state_q == S_RESP);
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req_op)
						OP_APPEND: begin
							ram_we    = !cnt_full;
							ram_waddr = AW'(count_q);
							ram_wdata = req_value;
						end
						OP_INSERT: begin
							if (!pos_bad && !cnt_full) begin
								if (pos_end) begin
									ram_we    = 1'b1;
									ram_waddr = AW'(req_pos);
									ram_wdata = req_value;
								end else begin
									ram_re    = 1'b1;
									ram_raddr = AW'(count_q - CW'(1));
								end
							end
						end
						OP_DELETE: begin
							ram_re    = !cnt_zero;
							ram_raddr = AW'(count_q - CW'(1));
						end
						OP_DUMP: begin
							ram_re    = !cnt_zero;
							ram_raddr = '0;
						end
						default: ;
					endcase
				end
			end
			S_INS_SHIFT: begin
				// move one entry up, fetch the one below it
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = ram_rdata;
				ram_re    = !ins_done;
				ram_raddr = idx_q - AW'(2);
			end
			S_INS_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = val_q;
			end
			S_DEL_SRCH: begin
				if (hit) begin
					ram_re    = !tail_hit;
					ram_raddr = idx_q + AW'(1);
				end else begin
					ram_re    = !at_bottom;
					ram_raddr = idx_q - AW'(1);
				end
			end
			S_DEL_SHIFT: begin
				// close the gap: pull the next entry down
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = ram_rdata;
				ram_re    = !del_done;
				ram_raddr = idx_q + AW'(2);
			end
			S_RESP: begin
				ram_re    = res_ready && !last_q;
				ram_raddr = idx_q + AW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept && acc_status == STAT_OK && req_op == OP_APPEND) begin
				count_q <= count_q + CW'(1);
			end else if (accept && acc_status == STAT_OK && req_op == OP_INSERT && pos_end) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == S_INS_PUT) begin
				count_q <= count_q + CW'(1);
			end else if (state_q == S_DEL_SRCH && hit && tail_hit) begin
				count_q <= count_q - CW'(1);
			end else if (state_q == S_DEL_SHIFT && del_done) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					val_q    <= req_value;
					pos_q    <= AW'(req_pos);
					status_q <= acc_status;
					value_q  <= '0;
					last_q   <= 1'b1;
					unique case (req_op)
						OP_INSERT: idx_q <= AW'(count_q);
						OP_DELETE: idx_q <= AW'(count_q - CW'(1));
						default:   idx_q <= '0;
					endcase
				end
			end
			S_INS_SHIFT: begin
				if (!ins_done) begin
					idx_q <= idx_q - AW'(1);
				end
			end
			S_DEL_SRCH: begin
				if (hit) begin
					status_q <= STAT_OK;
				end else if (!at_bottom) begin
					idx_q <= idx_q - AW'(1);
				end
			end
			S_DEL_SHIFT: begin
				if (!del_done) begin
					idx_q <= idx_q + AW'(1);
				end
			end
			S_DUMP_RD: begin
				value_q <= ram_rdata;
				last_q  <= is_last;
			end
			S_RESP: begin
				if (res_ready && !last_q) begin
					idx_q <= idx_q + AW'(1);
				end
			end
			default: ;
		endcase
	end

	assign res = '{status:      status_q,
	               entry_value: value_q,
	               entry_count: CNT_W'(count_q),
	               last:        last_q};

endmodule
`default_nettype wire

FILE: hw/rtl/bounded_array_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_array_list
// Ordered list of signed 32-bit values in a RAM of CAPACITY entries.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream (operation, item_value, position) and are
// taken one at a time. Results leave on the m_ stream through an output
// register; m_tlast marks the final result of a request.
// Append, and insert at the current end, write the RAM when the request is
// taken and then answer. Insert at position p moves each entry from p up
// one place, one RAM read and one write per moved entry, then writes the
// new value. Delete searches down from the top for a match, then moves each
// entry above it down one place. Dump reads each entry from the RAM and
// hands it off as one result before it reads the next; an empty list gives
// a single result with status empty.
// The single RAM port pair limits each step of a walk to one read and at most
// one write.
// A stalled m_tready holds the result register and the sequencer; no new
// request is taken until every result of the current one has been handed
// to the output register.
// Reset clears the entry count; RAM contents need no clearing.
// ----------------------------------------------------------------------------
module bounded_array_list
	import bal_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [39:0]   s_tdata,   // operation[1:0], item_value[33:2], position[38:34]
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [39:0]        m_tdata,   // status[2:0], entry_value[34:3], entry_count[39:35]
	output logic               m_tlast
);

	localparam int AW = $clog2(CAPACITY);

	logic                 res_valid, res_ready;
	res_t                 res;
	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [VAL_W-1:0]     ram_wdata, ram_rdata;
	logic                 m_tvalid_q;
	logic [39:0]          m_tdata_q;
	logic                 m_tlast_q;

	bal_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req_op    (op_t'(s_tdata[1:0])),
		.req_value (s_tdata[33:2]),
		.req_pos   (s_tdata[38:34]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	bal_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// output register: load when empty or being drained
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= {res.entry_count, res.entry_value, res.status};
			m_tlast_q <= res.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule
`default_nettype wire
